### sv/umie_pkg.sv
// ----------------------------------------------------------------------------
// umie_pkg
// Shared types and constants of the UM-32 instruction execute block.
// ----------------------------------------------------------------------------
package umie_pkg;

  localparam int DATA_W       = 32;
  localparam int REG_N        = 8;
  localparam int REG_AW       = $clog2(REG_N);
  localparam int OPC_W        = 4;
  localparam int KIND_W       = 4;
  localparam int OPC_SHIFT    = 28;
  localparam int LV_REG_SHIFT = 25;
  localparam int LV_IMM_W     = 25;
  localparam int NUM_OPCODES  = 14;
  localparam int A_LSB        = 6;
  localparam int B_LSB        = 3;
  localparam int C_LSB        = 0;
  localparam int CHAR_W       = 8;
  localparam logic [DATA_W-1:0] OUT_BYTE_MAX = DATA_W'(255);

  // slave tdata: instruction, return_value, return_reg, in_char, in_end
  localparam int S_INSTR_LSB = 0;
  localparam int S_RVAL_LSB  = S_INSTR_LSB + DATA_W;
  localparam int S_RREG_LSB  = S_RVAL_LSB + DATA_W;
  localparam int S_CHAR_LSB  = S_RREG_LSB + REG_AW;
  localparam int S_END_LSB   = S_CHAR_LSB + CHAR_W;
  localparam int S_USED_W    = S_END_LSB + 1;
  localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

  // master tdata: segment, offset, value, dest_reg
  localparam int M_USED_W  = 3 * DATA_W + REG_AW;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [OPC_W-1:0] {
    OP_CMOV     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_STORE    = 4'd2,
    OP_ADD      = 4'd3,
    OP_MUL      = 4'd4,
    OP_DIV      = 4'd5,
    OP_NAND     = 4'd6,
    OP_HALT     = 4'd7,
    OP_MAP      = 4'd8,
    OP_UNMAP    = 4'd9,
    OP_OUT      = 4'd10,
    OP_IN       = 4'd11,
    OP_LOADPROG = 4'd12,
    OP_LOADVAL  = 4'd13
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DONE     = 4'd0,
    KIND_LOAD     = 4'd1,
    KIND_STORE    = 4'd2,
    KIND_MAP      = 4'd3,
    KIND_UNMAP    = 4'd4,
    KIND_OUTPUT   = 4'd5,
    KIND_LOADPROG = 4'd6,
    KIND_HALT     = 4'd7,
    KIND_ERROR    = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_READ_A,
    ST_EXEC,
    ST_DIV,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/umie_ram.sv
// ----------------------------------------------------------------------------
// umie_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module umie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

### sv/umie_div.sv
// ----------------------------------------------------------------------------
// umie_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module umie_div (
  input  logic              clk,
  input  logic              rst,
  input  umie_pkg::div_req_t req,
  output umie_pkg::div_rsp_t rsp
);
  import umie_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quot;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem, quot[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quot <= req.dividend;
      dvs  <= req.divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
      end else begin
        rem <= shifted[DATA_W-1:0];
      end
      quot <= {quot[DATA_W-2:0], ~diff[DATA_W]};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

### sv/um_instruction_execute.sv
// ----------------------------------------------------------------------------
// um_instruction_execute
// Executes one UM-32 instruction or register writeback per input beat.
// ----------------------------------------------------------------------------
// One beat is handled at a time. A beat goes through accept, register file
// read, execute and respond before its result sits in the output register;
// a store adds a second read pass, since its third operand needs a second
// pass through the two read ports of the register file, and a divide waits
// in between for the divider, which retires one quotient bit per cycle.
// The next beat is accepted as soon as the result is registered, even while
// that result still waits on m_tready. The eight registers read as zero
// after reset until written.
module um_instruction_execute (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // instruction, return_value, return_reg, in_char, in_end
  input  logic [umie_pkg::S_TDATA_W-1:0]  s_tdata,
  // action
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // segment, offset, value, dest_reg
  output logic [umie_pkg::M_TDATA_W-1:0]  m_tdata,
  // kind
  output logic [umie_pkg::KIND_W-1:0]     m_tuser
);
  import umie_pkg::*;

  state_t state, state_next;

  logic              action_q;
  logic [DATA_W-1:0] instr_q;
  logic [DATA_W-1:0] rval_q;
  logic [REG_AW-1:0] rreg_q;
  logic [CHAR_W-1:0] ch_q;
  logic              end_q;

  logic [DATA_W-1:0] va_q, vb_q, vc_q;
  logic [REG_N-1:0]  reg_valid;

  logic [REG_AW-1:0] rd_addr0, rd_addr1;
  logic [DATA_W-1:0] rd_data0, rd_data1;
  logic              ram_we;

  logic [REG_AW-1:0] ra, rb, rc;
  logic [OPC_W-1:0]  op_raw;
  logic              out_free;

  // execute results
  logic              e_wr_en;
  logic [REG_AW-1:0] e_wr_addr;
  logic [DATA_W-1:0] e_wr_data;
  kind_t             e_kind;
  logic [DATA_W-1:0] e_seg, e_off, e_val;
  logic [REG_AW-1:0] e_dest;
  logic              div_go;
  logic [DATA_W-1:0] prod;

  logic              wr_en;
  logic [REG_AW-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  kind_t             res_kind;
  logic [DATA_W-1:0] res_seg, res_off, res_val;
  logic [REG_AW-1:0] res_dest;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign ra       = instr_q[A_LSB +: REG_AW];
  assign rb       = instr_q[B_LSB +: REG_AW];
  assign rc       = instr_q[C_LSB +: REG_AW];
  assign op_raw   = instr_q[OPC_SHIFT +: OPC_W];
  assign out_free = !m_tvalid || m_tready;
  assign prod     = vb_q * vc_q;
  assign ram_we   = (state == ST_RESP) && out_free && wr_en;

  umie_ram #(
    .WIDTH(DATA_W),
    .DEPTH(REG_N)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr0(rd_addr0),
    .raddr1(rd_addr1),
    .rdata0(rd_data0),
    .rdata1(rd_data1)
  );

  assign div_req.start    = div_go;
  assign div_req.dividend = vb_q;
  assign div_req.divisor  = vc_q;

  umie_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (!action_q && op_raw == OP_STORE) begin
          state_next = ST_READ_A;
        end else begin
          state_next = ST_EXEC;
        end
      end
      ST_READ_A: state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = div_go ? ST_DIV : ST_RESP;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_addr0 = ra;
    rd_addr1 = rc;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        rd_addr0 = s_tdata[S_INSTR_LSB + B_LSB +: REG_AW];
        rd_addr1 = s_tdata[S_INSTR_LSB + C_LSB +: REG_AW];
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    e_wr_en   = 1'b0;
    e_wr_addr = ra;
    e_wr_data = '0;
    e_kind    = KIND_DONE;
    e_seg     = '0;
    e_off     = '0;
    e_val     = '0;
    e_dest    = '0;
    div_go    = 1'b0;
    if (state == ST_EXEC) begin
      if (action_q) begin
        e_wr_en   = 1'b1;
        e_wr_addr = rreg_q;
        e_wr_data = rval_q;
      end else if (op_raw >= OPC_W'(NUM_OPCODES)) begin
        e_kind = KIND_ERROR;
      end else begin
        case (opcode_t'(op_raw))
          OP_CMOV: begin
            e_wr_en   = (vc_q != '0);
            e_wr_data = vb_q;
          end
          OP_LOAD: begin
            e_kind = KIND_LOAD;
            e_seg  = vb_q;
            e_off  = vc_q;
            e_dest = ra;
          end
          OP_STORE: begin
            e_kind = KIND_STORE;
            e_seg  = va_q;
            e_off  = vb_q;
            e_val  = vc_q;
          end
          OP_ADD: begin
            e_wr_en   = 1'b1;
            e_wr_data = vb_q + vc_q;
          end
          OP_MUL: begin
            e_wr_en   = 1'b1;
            e_wr_data = prod;
          end
          OP_DIV: begin
            if (vc_q == '0) begin
              e_kind = KIND_ERROR;
            end else begin
              e_wr_en = 1'b1;
              div_go  = 1'b1;
            end
          end
          OP_NAND: begin
            e_wr_en   = 1'b1;
            e_wr_data = ~(vb_q & vc_q);
          end
          OP_HALT: e_kind = KIND_HALT;
          OP_MAP: begin
            e_kind = KIND_MAP;
            e_val  = vc_q;
            e_dest = rb;
          end
          OP_UNMAP: begin
            e_kind = KIND_UNMAP;
            e_seg  = vc_q;
          end
          OP_OUT: begin
            if (vc_q > OUT_BYTE_MAX) begin
              e_kind = KIND_ERROR;
            end else begin
              e_kind = KIND_OUTPUT;
              e_val  = vc_q;
            end
          end
          OP_IN: begin
            e_wr_en   = 1'b1;
            e_wr_addr = rc;
            e_wr_data = end_q ? '1 : DATA_W'(ch_q);
          end
          OP_LOADPROG: begin
            e_kind = KIND_LOADPROG;
            e_seg  = vb_q;
            e_val  = vc_q;
          end
          OP_LOADVAL: begin
            e_wr_en   = 1'b1;
            e_wr_addr = instr_q[LV_REG_SHIFT +: REG_AW];
            e_wr_data = DATA_W'(instr_q[LV_IMM_W-1:0]);
          end
          default: e_kind = KIND_ERROR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      action_q <= s_tuser;
      instr_q  <= s_tdata[S_INSTR_LSB +: DATA_W];
      rval_q   <= s_tdata[S_RVAL_LSB +: DATA_W];
      rreg_q   <= s_tdata[S_RREG_LSB +: REG_AW];
      ch_q     <= s_tdata[S_CHAR_LSB +: CHAR_W];
      end_q    <= s_tdata[S_END_LSB];
    end
    if (state == ST_READ) begin
      vb_q <= reg_valid[rb] ? rd_data0 : '0;
      vc_q <= reg_valid[rc] ? rd_data1 : '0;
    end
    if (state == ST_READ_A) begin
      va_q <= reg_valid[ra] ? rd_data0 : '0;
    end
    if (state == ST_EXEC) begin
      wr_en    <= e_wr_en;
      wr_addr  <= e_wr_addr;
      wr_data  <= e_wr_data;
      res_kind <= e_kind;
      res_seg  <= e_seg;
      res_off  <= e_off;
      res_val  <= e_val;
      res_dest <= e_dest;
    end
    if (state == ST_DIV && div_rsp.done) begin
      wr_data <= div_rsp.quotient;
    end
    if (state == ST_RESP && out_free) begin
      m_tuser <= res_kind;
      m_tdata <= M_TDATA_W'({res_dest, res_val, res_off, res_seg});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      reg_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        reg_valid[wr_addr] <= 1'b1;
      end
      if (state == ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### sv/umie_checker.sv
// ----------------------------------------------------------------------------
// umie_checker
// Port-level checks of the UM-32 instruction execute block.
// ----------------------------------------------------------------------------
module umie_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [umie_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [umie_pkg::KIND_W-1:0]    m_tuser
);
  import umie_pkg::*;

  logic [REG_AW-1:0] dest;
  assign dest = m_tdata[3*DATA_W +: REG_AW];

  // one beat in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // a result is not registered while its beat is still in the register file read
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !(m_tvalid && !m_tready)) |=> ##1 !$rose(m_tvalid))
    else $error("result appeared too early");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= KIND_W'(KIND_ERROR)))
    else $error("result kind out of range");

  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_W'(KIND_DONE) || m_tuser == KIND_W'(KIND_HALT)
                  || m_tuser == KIND_W'(KIND_ERROR))) |-> (m_tdata == '0))
    else $error("payload not zero for done, halt or error");

  a_dest_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && dest != '0) |->
      (m_tuser == KIND_W'(KIND_LOAD) || m_tuser == KIND_W'(KIND_MAP)))
    else $error("dest_reg set on a kind that awaits no reply");

endmodule

bind um_instruction_execute umie_checker u_umie_checker (.*);

### bench/um_instruction_execute_test.sv
// ----------------------------------------------------------------------------
// um_instruction_execute_test
// Self-checking bench for the UM-32 instruction execute block. A short
// directed run hits every opcode, both invalid opcodes, divide by zero, an
// out-of-range output byte, end of input, halt and unmap of segment 0. About
// 1700 random instruction and writeback beats follow. A scoreboard keeps its
// own copy of the register file and checks every result beat field by field.
// Both sides idle in random bursts, and the sink holds off once for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module um_instruction_execute_test;
  import umie_pkg::*;

  localparam int RANDOM_BEATS = 1700;
  localparam int QUIET_TAIL   = 300;
  localparam int HOLD_BEAT    = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int OPC_TOP      = (1 << OPC_W) - 1;

  typedef struct {
    kind_t             kind;
    logic [DATA_W-1:0] segment;
    logic [DATA_W-1:0] offset;
    logic [DATA_W-1:0] value;
    logic [REG_AW-1:0] dest_reg;
  } exec_result_t;

  class exec_scoreboard;
    logic [DATA_W-1:0] reg_file [REG_N];
    exec_result_t      expected_q [$];
    int                errors;
    int                beats;
    int                writebacks;
    int                checked;
    int                kind_seen [16];

    function new();
      foreach (reg_file[i]) reg_file[i] = '0;
    endfunction

    function void note_beat(logic wb, logic [S_TDATA_W-1:0] d);
      logic [DATA_W-1:0] instr;
      logic [DATA_W-1:0] vb;
      logic [DATA_W-1:0] vc;
      logic [OPC_W-1:0]  opc;
      logic [REG_AW-1:0] ra;
      logic [REG_AW-1:0] rb;
      logic [REG_AW-1:0] rc;
      exec_result_t      r;
      instr = d[S_INSTR_LSB +: DATA_W];
      opc   = instr[OPC_SHIFT +: OPC_W];
      ra    = instr[A_LSB +: REG_AW];
      rb    = instr[B_LSB +: REG_AW];
      rc    = instr[C_LSB +: REG_AW];
      vb    = reg_file[rb];
      vc    = reg_file[rc];
      r     = '{KIND_DONE, '0, '0, '0, '0};
      beats++;
      if (wb) begin
        writebacks++;
        reg_file[d[S_RREG_LSB +: REG_AW]] = d[S_RVAL_LSB +: DATA_W];
      end else if (opc >= NUM_OPCODES) begin
        r.kind = KIND_ERROR;
      end else begin
        case (opcode_t'(opc))
          OP_CMOV: if (vc != '0) reg_file[ra] = vb;
          OP_LOAD: begin
            r.kind = KIND_LOAD; r.segment = vb; r.offset = vc; r.dest_reg = ra;
          end
          OP_STORE: begin
            r.kind = KIND_STORE; r.segment = reg_file[ra]; r.offset = vb; r.value = vc;
          end
          OP_ADD:  reg_file[ra] = vb + vc;
          OP_MUL:  reg_file[ra] = vb * vc;
          OP_DIV: begin
            if (vc == '0) r.kind = KIND_ERROR;
            else reg_file[ra] = vb / vc;
          end
          OP_NAND: reg_file[ra] = ~(vb & vc);
          OP_HALT: r.kind = KIND_HALT;
          OP_MAP: begin
            r.kind = KIND_MAP; r.value = vc; r.dest_reg = rb;
          end
          OP_UNMAP: begin
            r.kind = KIND_UNMAP; r.segment = vc;
          end
          OP_OUT: begin
            if (vc > OUT_BYTE_MAX) r.kind = KIND_ERROR;
            else begin
              r.kind = KIND_OUTPUT; r.value = vc;
            end
          end
          OP_IN: reg_file[rc] = d[S_END_LSB] ? '1 : DATA_W'(d[S_CHAR_LSB +: CHAR_W]);
          OP_LOADPROG: begin
            r.kind = KIND_LOADPROG; r.segment = vb; r.value = vc;
          end
          default: reg_file[instr[LV_REG_SHIFT +: REG_AW]] = DATA_W'(instr[LV_IMM_W-1:0]);
        endcase
      end
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch, result beat %0d: %s", checked, msg);
      errors++;
    endtask

    task compare_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(logic [KIND_W-1:0] kind, logic [M_TDATA_W-1:0] d);
      exec_result_t w;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("beat of kind %0d with nothing expected", kind));
        return;
      end
      w = expected_q.pop_front();
      checked++;
      kind_seen[kind]++;
      compare_field("kind", DATA_W'(kind), DATA_W'(w.kind));
      compare_field("segment", d[0 +: DATA_W], w.segment);
      compare_field("offset", d[DATA_W +: DATA_W], w.offset);
      compare_field("value", d[2*DATA_W +: DATA_W], w.value);
      compare_field("dest_reg", DATA_W'(d[3*DATA_W +: REG_AW]), DATA_W'(w.dest_reg));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]    m_tuser;

  exec_scoreboard sb;
  logic           idling_on;
  logic           hold_request;
  logic           hold_done;
  int             quiet_cycles;

  um_instruction_execute dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] op_word(opcode_t op, logic [REG_AW-1:0] a,
                                               logic [REG_AW-1:0] b, logic [REG_AW-1:0] c);
    logic [DATA_W-1:0] w;
    w = $urandom;
    w[OPC_SHIFT +: OPC_W] = op;
    w[A_LSB +: REG_AW]    = a;
    w[B_LSB +: REG_AW]    = b;
    w[C_LSB +: REG_AW]    = c;
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] lv_word(logic [REG_AW-1:0] r, logic [LV_IMM_W-1:0] imm);
    return {OP_LOADVAL, r, imm};
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 1;
      3: return $urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic wb, logic [DATA_W-1:0] instr, logic [DATA_W-1:0] rval,
                           logic [REG_AW-1:0] rreg, logic [CHAR_W-1:0] ch, logic ended);
    s_tdata                          = '0;
    s_tdata[S_INSTR_LSB +: DATA_W]   = instr;
    s_tdata[S_RVAL_LSB +: DATA_W]    = rval;
    s_tdata[S_RREG_LSB +: REG_AW]    = rreg;
    s_tdata[S_CHAR_LSB +: CHAR_W]    = ch;
    s_tdata[S_END_LSB]               = ended;
    s_tuser                          = wb;
    s_tvalid                         = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic exec_instr(logic [DATA_W-1:0] instr);
    send_beat(1'b0, instr, $urandom, REG_AW'($urandom_range(0, 7)),
              CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_back(logic [REG_AW-1:0] r, logic [DATA_W-1:0] v);
    send_beat(1'b1, $urandom, v, r, CHAR_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic idle_sender(int n);
    s_tvalid = 1'b0;
    s_tdata  = S_TDATA_W'({$urandom, $urandom, $urandom});
    repeat (n) @(negedge clk);
  endtask

  // sink: random stalls, one long hold on request
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] w;
    int                sel;
    sb           = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    idling_on    = 1'b1;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    exec_instr('0);
    exec_instr('1);
    exec_instr({OPC_W'(NUM_OPCODES), 28'($urandom)});
    send_beat(1'b1, '1, '1, 3'd7, 8'hFF, 1'b1);
    send_beat(1'b1, '0, '0, 3'd0, 8'h00, 1'b0);
    exec_instr(lv_word(3'd1, '1));
    exec_instr(lv_word(3'd2, '0));
    exec_instr(lv_word(3'd3, 25'd3));
    exec_instr(op_word(OP_ADD, 3'd4, 3'd7, 3'd3));
    exec_instr(op_word(OP_MUL, 3'd5, 3'd7, 3'd1));
    exec_instr(op_word(OP_DIV, 3'd6, 3'd7, 3'd3));
    exec_instr(op_word(OP_DIV, 3'd6, 3'd1, 3'd2));
    exec_instr(op_word(OP_NAND, 3'd4, 3'd7, 3'd7));
    exec_instr(op_word(OP_CMOV, 3'd5, 3'd1, 3'd3));
    exec_instr(op_word(OP_CMOV, 3'd5, 3'd7, 3'd2));
    send_beat(1'b0, op_word(OP_IN, 3'd0, 3'd0, 3'd6), $urandom, 3'd2, 8'hA5, 1'b0);
    send_beat(1'b0, op_word(OP_IN, 3'd0, 3'd0, 3'd2), $urandom, 3'd5, 8'h00, 1'b1);
    exec_instr(op_word(OP_OUT, 3'd0, 3'd0, 3'd6));
    exec_instr(op_word(OP_OUT, 3'd0, 3'd0, 3'd7));
    exec_instr(op_word(OP_LOAD, 3'd1, 3'd3, 3'd1));
    exec_instr(op_word(OP_STORE, 3'd1, 3'd3, 3'd6));
    exec_instr(op_word(OP_MAP, 3'd0, 3'd5, 3'd3));
    exec_instr(op_word(OP_UNMAP, 3'd0, 3'd0, 3'd0));
    exec_instr(op_word(OP_LOADPROG, 3'd0, 3'd0, 3'd3));
    exec_instr(op_word(OP_HALT, 3'd0, 3'd0, 3'd0));
    exec_instr(lv_word(3'd0, 25'd77));

    // random
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      idling_on = (i < RANDOM_BEATS - QUIET_TAIL) && ((i / 150) % 3 != 2);
      if (i == HOLD_BEAT) hold_request = 1'b1;
      if (idling_on && !(hold_request && !hold_done) && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 6));
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        write_back(REG_AW'($urandom_range(0, 7)), pick_value());
      end else if (sel < 25) begin
        exec_instr(lv_word(REG_AW'($urandom_range(0, 7)),
                           $urandom_range(0, 1) ? LV_IMM_W'($urandom_range(0, 300))
                                                : LV_IMM_W'($urandom)));
      end else if (sel < 28) begin
        w = $urandom;
        w[OPC_SHIFT +: OPC_W] = OPC_W'($urandom_range(NUM_OPCODES, OPC_TOP));
        exec_instr(w);
      end else begin
        w = $urandom;
        w[OPC_SHIFT +: OPC_W] = OPC_W'($urandom_range(0, NUM_OPCODES - 2));
        send_beat(1'b0, w, $urandom, REG_AW'($urandom_range(0, 7)),
                  CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
    s_tvalid = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beats (%0d writebacks), all opcodes, invalid opcodes, %0d-cycle hold",
             sb.beats, sb.writebacks, HOLD_CYCLES);
    $display("results: done %0d load %0d store %0d map %0d unmap %0d",
             sb.kind_seen[KIND_DONE], sb.kind_seen[KIND_LOAD], sb.kind_seen[KIND_STORE],
             sb.kind_seen[KIND_MAP], sb.kind_seen[KIND_UNMAP]);
    $display("         out %0d prog %0d halt %0d err %0d",
             sb.kind_seen[KIND_OUTPUT], sb.kind_seen[KIND_LOADPROG],
             sb.kind_seen[KIND_HALT], sb.kind_seen[KIND_ERROR]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### um_instruction_execute.f
sv/umie_pkg.sv
sv/umie_ram.sv
sv/umie_div.sv
sv/um_instruction_execute.sv
sv/umie_checker.sv
bench/um_instruction_execute_test.sv
